[rtl/single_source_shortest_path_defines.svh]
// Assertion macros used by the checker of the shortest-path block.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSSP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSSP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sssp_pkg.sv]
// Package with the types, constants and state encoding of the shortest-path block.
package sssp_pkg;

    localparam int VIDX_BITS    = 4;
    localparam int MAX_VERTICES = 1 << VIDX_BITS;
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_BITS    = 2 * VIDX_BITS;
    localparam int LINK_DEPTH   = MAX_VERTICES * MAX_VERTICES;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 20;
    localparam int VCOUNT_BITS  = 5;

    typedef logic [VIDX_BITS-1:0]   vidx_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [DIST_BITS-1:0]   dist_t;
    typedef logic [VCOUNT_BITS-1:0] vcount_t;

    localparam vcount_t VERTEX_COUNT_RESET = VCOUNT_BITS'(9);
    localparam vcount_t VCOUNT_MAX         = VCOUNT_BITS'(MAX_VERTICES);
    localparam cnt_t    CNT_MAX            = CNT_BITS'(MAX_VERTICES);
    localparam dist_t   DIST_MAX           = '1;

    localparam logic ACTION_ADD_EDGE = 1'b0;
    localparam logic ACTION_COMPUTE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_STORED     = 2'd0,
        STATUS_REJECTED   = 2'd1,
        STATUS_ROW        = 2'd2,
        STATUS_BAD_SOURCE = 2'd3
    } status_t;

    typedef struct packed {
        logic          action;
        logic [3:0]    first_vertex;
        logic [3:0]    second_vertex;
        logic [15:0]   edge_weight_in;
        logic [3:0]    source_vertex;
    } in_item_t;

    typedef struct packed {
        status_t       status;
        logic [3:0]    vertex;
        logic [19:0]   distance;
        logic          reached;
        logic          last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_CMP,
        ST_EDGE_WR2,
        ST_RESP,
        ST_Q_INIT,
        ST_SELECT,
        ST_SETTLE,
        ST_RELAX,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic    en;
        addr_t   addr;
        weight_t weight;
    } graph_wr_t;

    typedef struct packed {
        dist_t base;
        dist_t addend;
        dist_t limit;
    } alu_req_t;

    typedef struct packed {
        dist_t sum;
        logic  less;
    } alu_rsp_t;

endpackage

[rtl/single_source_shortest_path.sv]
// Top level of the shortest-path block: sequencer, distance file and output register.
//
// The block holds an undirected weighted graph of up to 16 vertices and runs
// Dijkstra queries on it. Input words arrive on s_valid/s_ready/s_data, result
// words leave on m_valid/m_ready/m_data, and cfg_we/cfg_wdata set the number of
// vertices in use (reset value 9, values above 16 act as 16).
// An add-edge word raises m_valid with its status word once the stored weight
// has been read and compared against the new one and, if the new one is lighter
// or none was stored, both directions have been written. A rejected edge or a
// bad source goes straight to its status word. A compute word with a valid
// source returns one distance word per vertex in index order, the final one
// flagged with last. The words leave once no reached vertex is left unsettled,
// one per cycle while the receiver does not stall, and s_ready is back once the
// final word is in the output register. Each round scans all vertices in use
// for the nearest unsettled one, then relaxes one matrix row, one vertex per
// cycle through the single adder/comparator and the one weight memory port;
// unreached vertices cut the number of rounds.
// The block works on one word at a time; s_ready is high only while idle. A
// stalled receiver holds the one output register and the sequencer waits.
// Reset clears all edges, restores the vertex count and empties the output.
module single_source_shortest_path (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sssp_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sssp_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  sssp_pkg::vcount_t    cfg_wdata
);
    import sssp_pkg::*;

    state_t                  state_reg, state_next;
    vcount_t                 vcount_reg;
    cnt_t                    cnt_now;
    cnt_t                    cnt_reg, cnt_next;
    vidx_t                   a_reg, a_next;
    vidx_t                   b_reg, b_next;
    weight_t                 w_reg, w_next;
    vidx_t                   src_reg, src_next;
    status_t                 status_reg, status_next;
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [MAX_VERTICES-1:0] settled_reg, settled_next;
    dist_t                   dist_reg [MAX_VERTICES];
    dist_t                   dist_next [MAX_VERTICES];
    cnt_t                    scan_reg, scan_next;
    logic                    found_reg, found_next;
    dist_t                   best_reg, best_next;
    vidx_t                   u_reg, u_next;
    logic                    pend_valid_reg, pend_valid_next;
    vidx_t                   pend_idx_reg, pend_idx_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    vidx_t     scan_idx;
    logic      slot_free;
    logic      scan_last;
    logic      edge_oob;
    logic      src_bad;
    addr_t     rd_addr;
    graph_wr_t graph_wr;
    logic      rd_present;
    weight_t   rd_weight;
    alu_req_t  alu_req;
    alu_rsp_t  alu_rsp;

    // Vertex count saturates at the size of the matrix.
    assign cnt_now   = (vcount_reg > VCOUNT_MAX) ? CNT_MAX : CNT_BITS'(vcount_reg);
    assign scan_idx  = scan_reg[VIDX_BITS-1:0];
    assign scan_last = (scan_reg + cnt_t'(1)) == cnt_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign edge_oob  = (cnt_t'(s_data.first_vertex) >= cnt_now) ||
                       (cnt_t'(s_data.second_vertex) >= cnt_now);
    assign src_bad   = cnt_t'(s_data.source_vertex) >= cnt_now;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    sssp_graph u_graph (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_addr    (rd_addr),
        .wr         (graph_wr),
        .rd_present (rd_present),
        .rd_weight  (rd_weight)
    );

    sssp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.action == ACTION_COMPUTE) begin
                        state_next = src_bad ? ST_RESP : ST_Q_INIT;
                    end else begin
                        state_next = edge_oob ? ST_RESP : ST_EDGE_CMP;
                    end
                end
            end
            ST_EDGE_CMP: begin
                state_next = (!rd_present || alu_rsp.less) ? ST_EDGE_WR2 : ST_RESP;
            end
            ST_EDGE_WR2: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_INIT: begin
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                if (scan_last) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = found_reg ? ST_RELAX : ST_EMIT;
            end
            ST_RELAX: begin
                if ((scan_reg == cnt_reg) && !pend_valid_reg) begin
                    state_next = ST_SELECT;
                end
            end
            ST_EMIT: begin
                if (slot_free && scan_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory address, memory write and the operands of the shared unit.
    always_comb begin
        rd_addr         = {u_reg, scan_idx};
        graph_wr.en     = 1'b0;
        graph_wr.addr   = {a_reg, b_reg};
        graph_wr.weight = w_reg;
        alu_req.base    = DIST_BITS'(w_reg);
        alu_req.addend  = '0;
        alu_req.limit   = DIST_BITS'(rd_weight);
        case (state_reg)
            ST_IDLE: begin
                rd_addr = {s_data.first_vertex, s_data.second_vertex};
            end
            ST_EDGE_CMP: begin
                // Keep the smaller weight of parallel edges.
                graph_wr.en = !rd_present || alu_rsp.less;
            end
            ST_EDGE_WR2: begin
                graph_wr.en   = 1'b1;
                graph_wr.addr = {b_reg, a_reg};
            end
            ST_SELECT: begin
                alu_req.base  = dist_reg[scan_idx];
                alu_req.limit = best_reg;
            end
            ST_RELAX: begin
                alu_req.base   = best_reg;
                alu_req.addend = DIST_BITS'(rd_weight);
                alu_req.limit  = dist_reg[pend_idx_reg];
            end
            default: begin
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        src_next        = src_reg;
        status_next     = status_reg;
        reached_next    = reached_reg;
        settled_next    = settled_reg;
        dist_next       = dist_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        u_next          = u_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next = cnt_now;
                    a_next   = s_data.first_vertex;
                    b_next   = s_data.second_vertex;
                    w_next   = s_data.edge_weight_in[WEIGHT_BITS-1:0];
                    src_next = s_data.source_vertex;
                    if (s_data.action == ACTION_COMPUTE) begin
                        status_next = STATUS_BAD_SOURCE;
                    end else begin
                        status_next = edge_oob ? STATUS_REJECTED : STATUS_STORED;
                    end
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.status   = status_reg;
                    m_data_next.vertex   = '0;
                    m_data_next.distance = '0;
                    m_data_next.reached  = 1'b0;
                    m_data_next.last     = 1'b1;
                end
            end
            ST_Q_INIT: begin
                reached_next          = '0;
                reached_next[src_reg] = 1'b1;
                settled_next          = '0;
                dist_next[src_reg]    = '0;
                scan_next             = '0;
                found_next            = 1'b0;
            end
            ST_SELECT: begin
                // Strict compare keeps the lowest index among equal distances.
                if (reached_reg[scan_idx] && !settled_reg[scan_idx] &&
                        (!found_reg || alu_rsp.less)) begin
                    found_next = 1'b1;
                    best_next  = dist_reg[scan_idx];
                    u_next     = scan_idx;
                end
                scan_next = scan_last ? '0 : scan_reg + cnt_t'(1);
            end
            ST_SETTLE: begin
                if (found_reg) begin
                    settled_next[u_reg] = 1'b1;
                end
                scan_next       = '0;
                pend_valid_next = 1'b0;
            end
            ST_RELAX: begin
                if (scan_reg != cnt_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_idx;
                    scan_next       = scan_reg + cnt_t'(1);
                end else begin
                    pend_valid_next = 1'b0;
                end
                if (pend_valid_reg && rd_present && !settled_reg[pend_idx_reg] &&
                        (!reached_reg[pend_idx_reg] || alu_rsp.less)) begin
                    dist_next[pend_idx_reg]    = alu_rsp.sum;
                    reached_next[pend_idx_reg] = 1'b1;
                end
                if ((scan_reg == cnt_reg) && !pend_valid_reg) begin
                    scan_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.status   = STATUS_ROW;
                    m_data_next.vertex   = scan_idx;
                    m_data_next.distance = reached_reg[scan_idx] ? dist_reg[scan_idx] : '0;
                    m_data_next.reached  = reached_reg[scan_idx];
                    m_data_next.last     = scan_last;
                    scan_next            = scan_reg + cnt_t'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            vcount_reg     <= VERTEX_COUNT_RESET;
            reached_reg    <= '0;
            settled_reg    <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            reached_reg    <= reached_next;
            settled_reg    <= settled_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        w_reg        <= w_next;
        src_reg      <= src_next;
        status_reg   <= status_next;
        dist_reg     <= dist_next;
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        u_reg        <= u_next;
        pend_idx_reg <= pend_idx_next;
        m_data_reg   <= m_data_next;
    end

endmodule

[rtl/sssp_alu.sv]
// Shared saturating adder and less-than compare of the shortest-path block.
module sssp_alu (
    input  sssp_pkg::alu_req_t req,
    output sssp_pkg::alu_rsp_t rsp
);
    import sssp_pkg::*;

    logic [DIST_BITS:0] raw_sum;
    dist_t              sat_sum;

    assign raw_sum  = {1'b0, req.base} + {1'b0, req.addend};
    assign sat_sum  = raw_sum[DIST_BITS] ? DIST_MAX : raw_sum[DIST_BITS-1:0];
    assign rsp.sum  = sat_sum;
    assign rsp.less = sat_sum < req.limit;

endmodule

[rtl/sssp_graph.sv]
// Adjacency store: presence flags in flip-flops and a weight memory with registered read.
module sssp_graph (
    input  logic                aclk,
    input  logic                aresetn,
    input  sssp_pkg::addr_t     rd_addr,
    input  sssp_pkg::graph_wr_t wr,
    output logic                rd_present,
    output sssp_pkg::weight_t   rd_weight
);
    import sssp_pkg::*;

    logic [LINK_DEPTH-1:0] present_reg;
    weight_t               weight_mem [LINK_DEPTH];
    logic                  rd_present_reg;
    weight_t               rd_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '0;
            rd_present_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                present_reg[wr.addr] <= 1'b1;
            end
            rd_present_reg <= present_reg[rd_addr];
        end
    end

    // Weight entries are read every cycle; the top level uses one only where its presence flag is set.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            weight_mem[wr.addr] <= wr.weight;
        end
        rd_weight_reg <= weight_mem[rd_addr];
    end

    assign rd_present = rd_present_reg;
    assign rd_weight  = rd_weight_reg;

endmodule

[rtl/sssp_checker.sv]
// Port-level checker of the shortest-path block and its bind to the top level.
`include "single_source_shortest_path_defines.svh"

module sssp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sssp_pkg::out_item_t m_data
);
    import sssp_pkg::*;

    `SSSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result word changed")
    `SSSP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted on two cycles in a row")
    `SSSP_ASSERT_NOW(a_no_input_mid_rows, aclk, aresetn, m_valid && !m_data.last, !s_ready, "input ready while distance rows remain")
    `SSSP_ASSERT_NOW(a_status_word_shape, aclk, aresetn, m_valid && (m_data.status != STATUS_ROW), m_data.last && !m_data.reached && (m_data.distance == '0) && (m_data.vertex == '0), "malformed status word")
    `SSSP_ASSERT_NOW(a_unreached_zero, aclk, aresetn, m_valid && (m_data.status == STATUS_ROW) && !m_data.reached, m_data.distance == '0, "unreached vertex with nonzero distance")

endmodule

bind single_source_shortest_path sssp_checker u_sssp_checker (.*);

[sim/single_source_shortest_path_tb.sv]
// Self-checking testbench for the shortest-path block: edges, Dijkstra queries, vertex counts.
`timescale 1ns / 1ps

module single_source_shortest_path_tb;

    import sssp_pkg::*;

    // The watchdog limit is several times the longer of two quiet stretches: the
    // wait of a query at 16 vertices before its first row and the long receiver
    // hold-off of LONG_HOLD_CYCLES.
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int QUIET_LIMIT      = 10000;
    localparam int DRAIN_CYCLES     = 64;

    // Receiver behavior, re-chosen at random by the result sink.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } sink_mode_t;

    // Holds a private copy of the graph and the vertex count, predicts the words
    // that each accepted input word causes, and checks result words in order.
    class distance_scoreboard;
        bit          edge_known [LINK_DEPTH];
        weight_t     edge_cost  [LINK_DEPTH];
        vcount_t     vertex_count;
        out_item_t   expected_rows [$];
        int unsigned mismatches;
        int unsigned rows_checked;
        int unsigned edges_stored;
        int unsigned edges_rejected;
        int unsigned queries_run;
        int unsigned bad_sources;

        function new();
            foreach (edge_known[i]) begin
                edge_known[i] = 1'b0;
                edge_cost[i]  = '0;
            end
            vertex_count   = VERTEX_COUNT_RESET;
            mismatches     = 0;
            rows_checked   = 0;
            edges_stored   = 0;
            edges_rejected = 0;
            queries_run    = 0;
            bad_sources    = 0;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // Appends one predicted word at the tail of the queue.
        function void expect_row(out_item_t r);
            expected_rows.insert(expected_rows.size(), r);
        endfunction

        function out_item_t pack_result(status_t st, vidx_t v, dist_t d, logic hit, logic fin);
            out_item_t r;
            r.status   = st;
            r.vertex   = v;
            r.distance = d;
            r.reached  = hit;
            r.last     = fin;
            return r;
        endfunction

        // Parallel edges collapse to the lightest one.
        function void keep_lighter(int a, int b, weight_t w);
            int slot;
            slot = a * MAX_VERTICES + b;
            if (!edge_known[slot] || w < edge_cost[slot]) begin
                edge_known[slot] = 1'b1;
                edge_cost[slot]  = w;
            end
        endfunction

        function void note_word(in_item_t w);
            int          n;
            int          pick;
            int          round;
            int          i;
            int          slot;
            bit          found;
            bit          hit  [MAX_VERTICES];
            bit          done [MAX_VERTICES];
            int unsigned path_len [MAX_VERTICES];
            int unsigned nearest;
            int unsigned sum;
            n = (vertex_count > VCOUNT_MAX) ? MAX_VERTICES : int'(vertex_count);
            if (w.action == ACTION_ADD_EDGE) begin
                if (int'(w.first_vertex) >= n || int'(w.second_vertex) >= n) begin
                    expect_row(pack_result(STATUS_REJECTED, '0, '0, 1'b0, 1'b1));
                    edges_rejected++;
                end else begin
                    keep_lighter(int'(w.first_vertex), int'(w.second_vertex),
                                 w.edge_weight_in);
                    keep_lighter(int'(w.second_vertex), int'(w.first_vertex),
                                 w.edge_weight_in);
                    expect_row(pack_result(STATUS_STORED, '0, '0, 1'b0, 1'b1));
                    edges_stored++;
                end
                return;
            end
            if (int'(w.source_vertex) >= n) begin
                expect_row(pack_result(STATUS_BAD_SOURCE, '0, '0, 1'b0, 1'b1));
                bad_sources++;
                return;
            end
            queries_run++;
            foreach (hit[k]) begin
                hit[k]      = 1'b0;
                done[k]     = 1'b0;
                path_len[k] = 0;
            end
            hit[w.source_vertex] = 1'b1;
            for (round = 0; round < n; round++) begin
                // Nearest unsettled vertex; a strict compare keeps the lowest index on ties.
                found   = 1'b0;
                nearest = 0;
                pick    = 0;
                for (i = 0; i < n; i++) begin
                    if (hit[i] && !done[i] && (!found || path_len[i] < nearest)) begin
                        found   = 1'b1;
                        nearest = path_len[i];
                        pick    = i;
                    end
                end
                if (!found)
                    break;
                done[pick] = 1'b1;
                for (i = 0; i < n; i++) begin
                    slot = pick * MAX_VERTICES + i;
                    if (!edge_known[slot] || done[i])
                        continue;
                    sum = path_len[pick] + 32'(edge_cost[slot]);
                    if (sum > 32'(DIST_MAX))
                        sum = 32'(DIST_MAX);
                    if (!hit[i] || sum < path_len[i]) begin
                        path_len[i] = sum;
                        hit[i]      = 1'b1;
                    end
                end
            end
            for (i = 0; i < n; i++) begin
                expect_row(pack_result(STATUS_ROW, vidx_t'(i),
                    hit[i] ? dist_t'(path_len[i]) : dist_t'(0), hit[i], i == n - 1));
            end
        endfunction

        function void check_word(out_item_t got);
            out_item_t want;
            if (expected_rows.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: status %0d vertex %0d distance %0d %s%0b %s%0b",
                             got.status, got.vertex, got.distance,
                             "reached ", got.reached, "last ", got.last);
                mismatches++;
                return;
            end
            want = expected_rows.pop_front();
            rows_checked++;
            if (got.status !== want.status || got.vertex !== want.vertex ||
                got.distance !== want.distance || got.reached !== want.reached ||
                got.last !== want.last) begin
                if (mismatches < 10) begin
                    $write("result mismatch: expected status %0d vertex %0d distance %0d",
                           want.status, want.vertex, want.distance);
                    $write(" reached %0b last %0b,", want.reached, want.last);
                    $write(" got status %0d vertex %0d distance %0d",
                           got.status, got.vertex, got.distance);
                    $display(" reached %0b last %0b", got.reached, got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    vcount_t    cfg_wdata = '0;

    distance_scoreboard ledger = new();

    // Set by the stimulus to ask the receiver for one long hold-off; the receiver clears it.
    bit          hold_request  = 1'b0;
    int unsigned holds_done    = 0;
    int unsigned settings_seen = 0;
    int unsigned burst_left    = 0;
    int unsigned quiet_cycles  = 0;

    single_source_shortest_path i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock period: 6 ns low, 6 ns high.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Both handshakes are observed at the rising edge, before the block's own
    // registers update, so a word is counted exactly when it is accepted.
    // Input words are noted first; a result can never belong to a word accepted
    // at the same edge anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                ledger.note_word(s_data);
            if (m_valid && m_ready)
                ledger.check_word(m_data);
        end
    end

    // The watchdog ends the run when no word has moved on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word accepted for %0d cycles, %0d results still due",
                     quiet_cycles, ledger.pending());
            $display("single_source_shortest_path_tb failed");
            $finish;
        end
    end

    // The receiver switches at random between four ready patterns: always ready, a coin
    // toss, a fixed quarter of the time, or nine in ten at random. On request it
    // holds ready low for a long stretch so the output register fills and input stalls.
    initial begin : result_sink
        sink_mode_t  mode;
        int unsigned tick;
        mode = SINK_OPEN;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                holds_done++;
            end
            if (tick % 97 == 0)
                mode = sink_mode_t'($urandom_range(0, 3));
            tick++;
            case (mode)
                SINK_OPEN: begin
                    m_ready = 1'b1;
                end
                SINK_COIN: begin
                    m_ready = 1'($urandom_range(0, 1));
                end
                SINK_SPARSE: begin
                    m_ready = (tick % 4 == 0);
                end
                default: begin
                    m_ready = ($urandom_range(0, 9) != 0);
                end
            endcase
        end
    end

    // Offers one word and returns at the falling edge after it was accepted. The
    // sender works in bursts; between bursts it usually drops valid for a random
    // gap, and sometimes runs straight on, which gives stretches without idling.
    // Valid is only lowered between words, never while a word waits.
    task automatic send_word(in_item_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap > 3) begin
                s_valid = 1'b0;
                repeat (gap - 3) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid = 1'b1;
        s_data  = w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    // The unused fields of each word carry random bits; the block must ignore them.
    task automatic add_edge(int a, int b, int w);
        in_item_t word;
        word.action         = ACTION_ADD_EDGE;
        word.first_vertex   = vidx_t'(a);
        word.second_vertex  = vidx_t'(b);
        word.edge_weight_in = weight_t'(w);
        word.source_vertex  = vidx_t'($urandom_range(0, 15));
        send_word(word);
    endtask

    task automatic query(int src);
        in_item_t word;
        word.action         = ACTION_COMPUTE;
        word.first_vertex   = vidx_t'($urandom_range(0, 15));
        word.second_vertex  = vidx_t'($urandom_range(0, 15));
        word.edge_weight_in = weight_t'($urandom_range(0, 65535));
        word.source_vertex  = vidx_t'(src);
        send_word(word);
    endtask

    // Stops offering and waits until every expected result has arrived and the
    // block is back in its idle state, which is the only time the vertex count
    // may change.
    task automatic wait_idle();
        s_valid    = 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (ledger.pending() != 0 || !s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_vertex_count(vcount_t value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        ledger.vertex_count = value;
        settings_seen++;
    endtask

    // A vertex inside the active range; with no vertices in use any index will do,
    // and every word is then rejected.
    function automatic int pick_vertex(int n);
        return (n == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    endfunction

    // Light weights half of the time so that the shortest paths are not trivial, plus the
    // extremes and full-range values.
    function automatic int pick_weight();
        case ($urandom_range(0, 7))
            0: begin
                return 0;
            end
            1: begin
                return 65535;
            end
            2, 3: begin
                return $urandom_range(0, 65535);
            end
            default: begin
                return $urandom_range(1, 400);
            end
        endcase
    endfunction

    // One vertex-count setting. Most traffic is a few in-range edges followed by a
    // query from a valid source; one step in ten instead sends one noise word: an
    // edge or a source drawn from the full index range, rejected when it falls outside.
    task automatic random_phase(vcount_t value, int budget, bit with_hold, bit with_pause);
        int n;
        int sent;
        int k;
        int j;
        write_vertex_count(value);
        n    = (value > VCOUNT_MAX) ? MAX_VERTICES : int'(value);
        sent = 0;
        while (sent < budget) begin
            if (sent >= budget / 2) begin
                if (with_hold) begin
                    hold_request = 1'b1;
                    with_hold    = 1'b0;
                end
                if (with_pause) begin
                    wait_idle();
                    with_pause = 1'b0;
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1))
                    add_edge($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
                else
                    query($urandom_range(0, 15));
                sent++;
            end else begin
                k = $urandom_range(1, 5);
                for (j = 0; j < k; j++)
                    add_edge(pick_vertex(n), pick_vertex(n), pick_weight());
                query(pick_vertex(n));
                sent += k + 1;
            end
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, at the reset count of nine vertices. A query on the empty
        // graph reaches only its source.
        query(0);
        // Heaviest weight on the highest valid vertex, then ends at and beyond the count.
        add_edge(0, 8, 65535);
        add_edge(9, 0, 7);
        add_edge(15, 15, 1);
        // A self loop is stored but never shortens anything.
        add_edge(3, 3, 7);
        // Parallel edges in both orientations: the lightest of the three must win.
        add_edge(1, 2, 100);
        add_edge(2, 1, 40);
        add_edge(1, 2, 200);
        add_edge(0, 1, 0);
        // Equal distances to vertices 3 and 4, and two equal routes into vertex 5,
        // so that the lowest index has to be settled first.
        add_edge(0, 3, 10);
        add_edge(0, 4, 10);
        add_edge(3, 5, 5);
        add_edge(4, 5, 5);
        query(0);
        // Sources at and far beyond the count are bad.
        query(9);
        query(15);
        query(8);
        // An isolated source.
        query(6);

        // Full size: a long heavy chain gives the largest distances.
        write_vertex_count(VCOUNT_MAX);
        add_edge(15, 14, 65535);
        add_edge(14, 8, 65535);
        query(15);
        add_edge(15, 0, 16'hAAAA);
        query(14);

        // Random part over several counts: the maximum, a value that saturates,
        // a lowered count that hides stored edges, one vertex, none, and a few more.
        random_phase(VCOUNT_MAX, 70, 1'b1, 1'b0);
        random_phase(vcount_t'(31), 60, 1'b0, 1'b0);
        random_phase(vcount_t'(12), 60, 1'b0, 1'b1);
        random_phase(vcount_t'(1), 30, 1'b0, 1'b0);
        random_phase(vcount_t'(0), 25, 1'b0, 1'b0);
        random_phase(vcount_t'(5), 60, 1'b0, 1'b0);
        random_phase(vcount_t'(2), 30, 1'b0, 1'b0);
        random_phase(VCOUNT_MAX, 70, 1'b0, 1'b0);
        random_phase(vcount_t'($urandom_range(0, 31)), 60, 1'b0, 1'b0);

        // Everything is sent: wait for the last results, then watch a little longer
        // for stray words.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $write("Run covered %0d stored and %0d rejected edges, %0d queries and",
               ledger.edges_stored, ledger.edges_rejected, ledger.queries_run);
        $display(" %0d bad sources over %0d vertex-count settings, with %0d long hold-offs.",
                 ledger.bad_sources, settings_seen, holds_done);
        $display("Checked %0d result words, %0d mismatching, %0d still outstanding.",
                 ledger.rows_checked, ledger.mismatches, ledger.pending());
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("single_source_shortest_path_tb passed");
        else
            $display("single_source_shortest_path_tb failed");
        $finish;
    end

endmodule
